/* rtl/ppr_pkg.sv */
// Package for the pinned page replacement buffer.
// Payload structs, command codes and the cell control group; no dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int KEY_W         = 56;
  localparam int VA_W          = 9;
  localparam int OCC_W         = 5;

  // command codes
  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_PIN    = 2'd1;
  localparam logic [1:0] CMD_UNPIN  = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // level-0 indexes at or below this value are ignored by access and remove
  localparam logic [VA_W-1:0] VA_FILTER_MAX = 9'd2;

  // replacement order register values
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] page_key;
    logic [VA_W-1:0]  va_index;
    logic             page_pinned;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic             all_pinned;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // update controls broadcast to every cell in the resolve cycle
  typedef struct packed {
    logic             commit;     // apply the update this cycle
    logic             del_match;  // delete the matching entry
    logic             evict;      // delete the first unpinned entry
    logic             del;        // one entry is deleted in total
    logic             append;     // write new entry at the back
    logic             set_pin;    // overwrite pin bit of matching entry
    logic             pin_val;
    logic [KEY_W-1:0] new_key;
    logic             new_pin;
  } cell_ctrl_t;

endpackage

/* rtl/ppr_cell.sv */
// One buffer slot: key, pin bit, registered match flag and compaction shift.
// Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_cell
  import ppr_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  // key capture at item transfer
  input  logic             cap_en,
  input  logic [KEY_W-1:0] cap_key,
  input  logic [CW-1:0]    count,
  input  cell_ctrl_t       ctrl,
  // neighbor toward the back
  input  logic [KEY_W-1:0] nb_key,
  input  logic             nb_pin,
  output logic [KEY_W-1:0] key_q,
  output logic             pin_q,
  // chains from the front
  input  logic             unpin_in,
  output logic             unpin_out,
  input  logic             shift_in,
  output logic             shift_out,
  input  logic [KEY_W-1:0] evk_in,
  output logic [KEY_W-1:0] evk_out,
  output logic             match_q
);

  logic [KEY_W-1:0] key_r;
  logic             pin_r;
  logic             match_r;
  logic             valid;
  logic             free_here;
  logic             sel;
  logic             app_here;

  assign valid     = CW'(IDX) < count;
  assign free_here = valid & ~pin_r & ~unpin_in;
  assign unpin_out = unpin_in | (valid & ~pin_r);

  // this slot is the one deleted
  assign sel       = (ctrl.del_match & match_r) | (ctrl.evict & free_here);
  assign shift_out = shift_in | sel;
  assign evk_out   = evk_in | ((ctrl.evict & free_here) ? key_r : '0);

  // back of the buffer after any deletion
  assign app_here  = ctrl.append && (CW'(IDX) == (count - CW'(ctrl.del)));

  assign key_q   = key_r;
  assign pin_q   = pin_r;
  assign match_q = match_r;

  // key storage, no reset
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (app_here) key_r <= ctrl.new_key;
      else if (shift_out) key_r <= nb_key;
    end
  end

  // pin bit and match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (cap_en) match_r <= valid && (key_r == cap_key);
      if (ctrl.commit) begin
        if (app_here) pin_r <= ctrl.new_pin;
        else if (shift_out) pin_r <= nb_pin;
        else if (ctrl.set_pin && match_r) pin_r <= ctrl.pin_val;
      end
    end
  end

endmodule

/* rtl/pinned_page_replacement_buffer.sv */
// A result is registered at the resolve edge, which waits while a stalled result
// is held. Input stalls until the item resolves; the transfer edge registers the
// key compare in every cell, the resolve edge resolves the eviction scan and shifts
// the cell chain. The output register frees the input side while a result waits.
// Reset (rst_n synchronous, low): buffer empty, pins cleared, policy LRU.
`timescale 1ns / 1ps

module pinned_page_replacement_buffer
  import ppr_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
  localparam int CW          = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic             busy_r;
  in_item_t         item_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             policy_r;

  logic             in_xfer;
  logic             resolve;
  cell_ctrl_t       ctrl;

  logic [BUFFER_DEPTH:0]  unpin_ch;
  logic [BUFFER_DEPTH:0]  shift_ch;
  logic [KEY_W-1:0]       evk_ch [BUFFER_DEPTH+1];
  logic [KEY_W-1:0]       key_v  [BUFFER_DEPTH+1];
  logic [BUFFER_DEPTH:0]  pin_v;
  logic [BUFFER_DEPTH-1:0] match_v;

  logic filt, hit_any, full, is_acc, found, hit_rep;

  assign in_xfer   = in_valid & ~in_stall;
  assign in_stall  = busy_r;
  assign resolve   = busy_r & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // chain ends
  assign unpin_ch[0]  = 1'b0;
  assign shift_ch[0]  = 1'b0;
  assign evk_ch[0]    = '0;
  assign key_v[BUFFER_DEPTH] = '0;
  assign pin_v[BUFFER_DEPTH] = 1'b0;

  // row of cells
  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    ppr_cell #(.DEPTH(BUFFER_DEPTH), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cap_en    (in_xfer),
      .cap_key   (in_data.page_key),
      .count     (count_r),
      .ctrl      (ctrl),
      .nb_key    (key_v[i+1]),
      .nb_pin    (pin_v[i+1]),
      .key_q     (key_v[i]),
      .pin_q     (pin_v[i]),
      .unpin_in  (unpin_ch[i]),
      .unpin_out (unpin_ch[i+1]),
      .shift_in  (shift_ch[i]),
      .shift_out (shift_ch[i+1]),
      .evk_in    (evk_ch[i]),
      .evk_out   (evk_ch[i+1]),
      .match_q   (match_v[i])
    );
  end

  // decode of the held item
  assign filt    = item_r.va_index <= VA_FILTER_MAX;
  assign hit_any = |match_v;
  assign full    = count_r == CW'(BUFFER_DEPTH);
  assign is_acc  = (item_r.command == CMD_ACCESS) & ~filt;
  assign found   = unpin_ch[BUFFER_DEPTH];

  always_comb begin
    ctrl.commit    = resolve;
    ctrl.del_match = hit_any & ((is_acc & (policy_r == POLICY_LRU)) |
                     ((item_r.command == CMD_REMOVE) & ~filt));
    ctrl.evict     = is_acc & ~hit_any & full;
    ctrl.del       = ctrl.del_match | (ctrl.evict & found);
    ctrl.append    = is_acc & (hit_any ? (policy_r == POLICY_LRU) : (~full | found));
    ctrl.set_pin   = hit_any & ((is_acc & (policy_r == POLICY_FIFO)) |
                     (item_r.command == CMD_PIN) | (item_r.command == CMD_UNPIN));
    ctrl.pin_val   = is_acc ? item_r.page_pinned : (item_r.command == CMD_PIN);
    ctrl.new_key   = item_r.page_key;
    ctrl.new_pin   = item_r.page_pinned;
  end

  assign hit_rep   = hit_any & (is_acc | (item_r.command == CMD_PIN) |
                     (item_r.command == CMD_UNPIN) |
                     ((item_r.command == CMD_REMOVE) & ~filt));
  assign count_nxt = count_r - CW'(ctrl.del) + CW'(ctrl.append);

  // item capture
  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_data;
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (resolve) begin
      out_data_r.hit         <= hit_rep;
      out_data_r.inserted    <= ctrl.append & ~hit_any;
      out_data_r.evicted     <= ctrl.evict & found;
      out_data_r.evicted_key <= evk_ch[BUFFER_DEPTH];
      out_data_r.all_pinned  <= ctrl.evict & ~found;
      out_data_r.occupancy   <= OCC_W'(count_nxt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      policy_r    <= POLICY_LRU;
    end else begin
      if (cfg_valid && cfg_ready) policy_r <= cfg_data;
      if (in_xfer) busy_r <= 1'b1;
      else if (resolve) busy_r <= 1'b0;
      if (resolve) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb_pinned_page_replacement_buffer.sv */
// Testbench for pinned_page_replacement_buffer: directed and random page commands,
// random gaps on both channels and checks of every result. Needs only ppr_pkg and the block.
`timescale 1ns / 1ps

// Keeps its own copy of the resident page buffer and queues the result of every
// accepted command, then compares each result from the block with the oldest one.
class page_buffer_scoreboard;
  localparam int DEPTH = ppr_pkg::DEFAULT_DEPTH;

  logic [ppr_pkg::KEY_W-1:0] page_keys [DEPTH];
  logic                      page_pins [DEPTH];
  int                        resident;
  logic                      policy;
  ppr_pkg::out_item_t        pending_outcomes [$];
  int                        mismatches;

  function new();
    resident   = 0;
    policy     = ppr_pkg::POLICY_LRU;
    mismatches = 0;
    foreach (page_pins[i]) begin
      page_pins[i] = 1'b0;
      page_keys[i] = '0;
    end
  endfunction

  function void set_policy(logic mode);
    policy = mode;
  endfunction

  function int outstanding();
    return pending_outcomes.size();
  endfunction

  // delete one entry and close the gap
  function void drop_slot(int pos);
    for (int i = pos; i + 1 < resident; i++) begin
      page_keys[i] = page_keys[i + 1];
      page_pins[i] = page_pins[i + 1];
    end
    resident--;
  endfunction

  function void push_back(logic [ppr_pkg::KEY_W-1:0] key, logic pin);
    if (resident < DEPTH) begin
      page_keys[resident] = key;
      page_pins[resident] = pin;
      resident++;
    end
  endfunction

  // work out the result of one accepted command and update the buffer
  function void note_command(ppr_pkg::in_item_t item);
    ppr_pkg::out_item_t outcome;
    int                 slot;
    logic               filtered;
    logic               room;
    outcome  = '0;
    slot     = -1;
    filtered = item.va_index <= ppr_pkg::VA_FILTER_MAX;
    for (int i = 0; i < resident; i++)
      if (slot < 0 && page_keys[i] == item.page_key) slot = i;

    case (item.command)
      ppr_pkg::CMD_ACCESS: begin
        if (!filtered) begin
          if (slot >= 0) begin
            outcome.hit     = 1'b1;
            page_pins[slot] = item.page_pinned;
            if (policy == ppr_pkg::POLICY_LRU) begin
              drop_slot(slot);
              push_back(item.page_key, item.page_pinned);
            end
          end else begin
            room = 1'b1;
            // full: evict the oldest unpinned page
            if (resident >= DEPTH) begin
              room = 1'b0;
              for (int i = 0; i < resident; i++) begin
                if (!page_pins[i]) begin
                  outcome.evicted     = 1'b1;
                  outcome.evicted_key = page_keys[i];
                  drop_slot(i);
                  room = 1'b1;
                  break;
                end
              end
            end
            if (room) begin
              push_back(item.page_key, item.page_pinned);
              outcome.inserted = 1'b1;
            end else begin
              outcome.all_pinned = 1'b1;
            end
          end
        end
      end
      ppr_pkg::CMD_PIN, ppr_pkg::CMD_UNPIN: begin
        // no level-0 filter here
        if (slot >= 0) begin
          outcome.hit     = 1'b1;
          page_pins[slot] = item.command == ppr_pkg::CMD_PIN;
        end
      end
      default: begin
        if (!filtered && slot >= 0) begin
          outcome.hit = 1'b1;
          drop_slot(slot);
        end
      end
    endcase
    outcome.occupancy = ppr_pkg::OCC_W'(resident);
    pending_outcomes.push_back(outcome);
  endfunction

  function void check_result(ppr_pkg::out_item_t got);
    ppr_pkg::out_item_t want;
    if (pending_outcomes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: hit=%0b ins=%0b ev=%0b evk=%h allp=%0b occ=%0d",
                 got.hit, got.inserted, got.evicted, got.evicted_key,
                 got.all_pinned, got.occupancy);
      return;
    end
    want = pending_outcomes.pop_front();
    if (got.hit !== want.hit || got.inserted !== want.inserted ||
        got.evicted !== want.evicted || got.evicted_key !== want.evicted_key ||
        got.all_pinned !== want.all_pinned || got.occupancy !== want.occupancy) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected hit=%0b ins=%0b ev=%0b evk=%h allp=%0b occ=%0d",
                 want.hit, want.inserted, want.evicted, want.evicted_key,
                 want.all_pinned, want.occupancy);
        $display("          actual   hit=%0b ins=%0b ev=%0b evk=%h allp=%0b occ=%0d",
                 got.hit, got.inserted, got.evicted, got.evicted_key,
                 got.all_pinned, got.occupancy);
      end
    end
  endfunction
endclass

module tb_pinned_page_replacement_buffer;
  import ppr_pkg::*;

  localparam int BUF_DEPTH   = DEFAULT_DEPTH;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 255;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  page_buffer_scoreboard sb = new();

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  bit               in_burst  = 1'b0;
  bit               out_burst = 1'b0;
  int               stall_left;
  int               cycles = 0;

  pinned_page_replacement_buffer #(.BUFFER_DEPTH(BUF_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transfer, then outside bursts mostly hold stall for a random count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 99) < 3) out_burst = !out_burst;
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        if (!out_burst && $urandom_range(0, 5) != 0) begin
          stall_left <= $urandom_range(1, 5);
          out_stall  <= 1'b1;
        end else begin
          stall_left <= 0;
          out_stall  <= 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= stall_left > 1;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                         logic [VA_W-1:0] va, logic pin);
    in_item_t item;
    item.command     = cmd;
    item.page_key    = key;
    item.va_index    = va;
    item.page_pinned = pin;
    return item;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  // mostly accesses to a small key set so the buffer fills and hits often
  function automatic in_item_t random_command(int pin_pct);
    int               pick;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VA_W-1:0]  va;
    pick = $urandom_range(0, 99);
    if (pick < 70)      cmd = CMD_ACCESS;
    else if (pick < 80) cmd = CMD_PIN;
    else if (pick < 90) cmd = CMD_UNPIN;
    else                cmd = CMD_REMOVE;
    key = ($urandom_range(0, 9) == 0) ? fresh_key() : key_pool[$urandom_range(0, POOL_SIZE - 1)];
    va  = ($urandom_range(0, 99) < 8) ? VA_W'($urandom_range(0, 2))
                                      : VA_W'($urandom_range(3, 511));
    return make_item(cmd, key, va, $urandom_range(0, 99) < pin_pct);
  endfunction

  // one input transfer; valid stays up across back-to-back items
  task automatic send_command(input in_item_t item);
    int gap;
    if ($urandom_range(0, 99) < 3) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(item);
  endtask

  // drop valid, wait for every result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_policy(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_policy(mode);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic phase_policy [6];
    int   phase_pin_pct [6];
    phase_policy  = '{POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                      POLICY_LRU, POLICY_FIFO, POLICY_LRU};
    phase_pin_pct = '{30, 90, 90, 10, 50, 60};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset policy (LRU)
    send_command(make_item(CMD_ACCESS, '0, 9'd0, 1'b1));        // filtered, empty buffer
    send_command(make_item(CMD_ACCESS, key_pool[0], 9'd1, 1'b0));
    send_command(make_item(CMD_REMOVE, '0, 9'd2, 1'b0));        // filtered remove
    send_command(make_item(CMD_PIN, key_pool[0], 9'd0, 1'b0));  // pin of absent key
    send_command(make_item(CMD_ACCESS, KEY_MAX, 9'd511, 1'b0)); // miss, insert
    send_command(make_item(CMD_ACCESS, '0, 9'd3, 1'b1));
    send_command(make_item(CMD_ACCESS, KEY_MAX, 9'd3, 1'b1));   // hit moves to back
    send_command(make_item(CMD_UNPIN, '0, 9'd0, 1'b1));         // no filter on unpin
    send_command(make_item(CMD_PIN, KEY_MAX, 9'd2, 1'b0));
    send_command(make_item(CMD_REMOVE, '0, 9'd511, 1'b1));      // remove that finds its key
    send_command(make_item(CMD_REMOVE, '0, 9'd100, 1'b0));      // remove of absent key
    // fill to full with pinned pages, then a miss with every entry pinned
    for (int i = 0; i < BUF_DEPTH - 1; i++)
      send_command(make_item(CMD_ACCESS, key_pool[i], VA_W'(3 + 37 * i), 1'b1));
    send_command(make_item(CMD_ACCESS, key_pool[20], 9'h155, 1'b0));
    send_command(make_item(CMD_UNPIN, key_pool[7], 9'h0aa, 1'b0));
    send_command(make_item(CMD_ACCESS, key_pool[21], 9'h1ff, 1'b0)); // evicts the unpinned one
    settle();

    // random phases, each with its own policy and pin density
    for (int p = 0; p < 6; p++) begin
      write_policy(phase_policy[p]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_command(random_command(phase_pin_pct[p]));
      settle();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
